FILE: hw/rtl/osft_pkg.sv
// Shared types and constants for the oxygen sensor fuel trim core.
// Used by osft_trim_step and oxygen_sensor_fuel_trim_core.
package osft_pkg;

   localparam logic [7:0] MAX_THROTTLE = 8'd200;
   localparam logic [7:0] MAX_PRESSURE = 8'd100;
   localparam logic [7:0] NEUTRAL_TRIM = 8'd100;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEP_SIZE     = 3'd0,
      CSR_RPM_MIN       = 3'd1,
      CSR_COOLANT_MIN   = 3'd2,
      CSR_SENSOR_TARGET = 3'd3,
      CSR_TRIM_LIMIT    = 3'd4,
      CSR_STEP_INTERVAL = 3'd5,
      CSR_WIDEBAND_MODE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [6:0] step_size;
      logic [7:0] rpm_min;
      logic [7:0] coolant_min;
      logic [7:0] sensor_target;
      logic [6:0] trim_limit;
      logic [7:0] step_interval;
      logic       wideband_mode;
   } cfg_type;

   typedef struct packed {
      logic [3:0] new_pulses;
      logic       sensor_not_ready;
      logic       enrich_active;
      logic [7:0] sensor_reading;
      logic [7:0] manifold_kpa;
      logic [7:0] throttle_pos;
      logic [7:0] coolant_temp;
      logic [7:0] engine_speed;
   } item_type;

   typedef struct packed {
      logic       stepped;
      logic       loop_open;
      logic [7:0] correction;
   } result_type;

endpackage

FILE: hw/rtl/oxygen_sensor_fuel_trim_core.sv
// Closed-loop exhaust oxygen fuel trim core: one result beat per request beat.
// Results are registered in the output register or the skid; one request beat per cycle while the skid is empty.
// Trim and pulse counter update at the accept edge; a two-entry result buffer
// (output register plus skid) keeps requests flowing while a result waits.
// Synchronous active-high reset: trim to 100, counter and config registers to 0, buffer empty.
// Depends on osft_pkg and osft_trim_step.
module oxygen_sensor_fuel_trim_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // engine_speed, coolant_temp, throttle_pos, manifold_kpa, sensor_reading,
   // enrich_active, sensor_not_ready, new_pulses, zero pad
   input  logic [osft_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // correction, loop_open, stepped, zero pad
   output logic [osft_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [osft_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [osft_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   osft_pkg::cfg_type    cfg_ff;
   osft_pkg::item_type   item;
   osft_pkg::result_type step_result;
   osft_pkg::result_type out_ff, out_in, skid_ff, skid_in;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic [7:0]           trim_ff, trim_in, pulse_ff, pulse_in;
   logic                 accept, take;

   assign item       = osft_pkg::item_type'(req_tdata[45:0]);
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && !skid_valid_ff;
   assign take       = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff};

   osft_trim_step u_step (
      .cfg        (cfg_ff),
      .item       (item),
      .trim_cur   (trim_ff),
      .pulse_cur  (pulse_ff),
      .trim_next  (trim_in),
      .pulse_next (pulse_in),
      .result     (step_result)
   );

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         trim_ff       <= osft_pkg::NEUTRAL_TRIM;
         pulse_ff      <= 8'd0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            trim_ff  <= trim_in;
            pulse_ff <= pulse_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            osft_pkg::CSR_STEP_SIZE:     cfg_ff.step_size     <= csr_wdata[6:0];
            osft_pkg::CSR_RPM_MIN:       cfg_ff.rpm_min       <= csr_wdata;
            osft_pkg::CSR_COOLANT_MIN:   cfg_ff.coolant_min   <= csr_wdata;
            osft_pkg::CSR_SENSOR_TARGET: cfg_ff.sensor_target <= csr_wdata;
            osft_pkg::CSR_TRIM_LIMIT:    cfg_ff.trim_limit    <= csr_wdata[6:0];
            osft_pkg::CSR_STEP_INTERVAL: cfg_ff.step_interval <= csr_wdata;
            osft_pkg::CSR_WIDEBAND_MODE: cfg_ff.wideband_mode <= csr_wdata[0];
            default:                     cfg_ff               <= cfg_ff;
         endcase
      end
   end

endmodule

FILE: hw/rtl/osft_trim_step.sv
// Combinational trim update for one beat: disable check, counter, step and clamp.
// Depends on osft_pkg.
module osft_trim_step (
   input  osft_pkg::cfg_type    cfg,
   input  osft_pkg::item_type   item,
   input  logic [7:0]           trim_cur,
   input  logic [7:0]           pulse_cur,
   output logic [7:0]           trim_next,
   output logic [7:0]           pulse_next,
   output osft_pkg::result_type result
);

   logic [8:0]        pulse_sum;
   logic [7:0]        pulse_sat;
   logic              open_loop;
   logic              do_step;
   logic              below;
   logic              lean;
   logic [8:0]        hi_lim;
   logic [8:0]        lean_sum;
   logic [7:0]        lean_val;
   logic signed [9:0] lo_lim;
   logic signed [9:0] rich_diff;
   logic signed [9:0] rich_clamp;
   logic [7:0]        rich_val;

   always_comb begin
      pulse_sum = {1'b0, pulse_cur} + {5'd0, item.new_pulses};
      pulse_sat = pulse_sum[8] ? 8'hFF : pulse_sum[7:0];

      open_loop = (cfg.step_size == 7'd0) || (item.engine_speed < cfg.rpm_min) ||
                  item.enrich_active || (item.coolant_temp < cfg.coolant_min) ||
                  (item.throttle_pos > osft_pkg::MAX_THROTTLE) || item.sensor_not_ready ||
                  (item.manifold_kpa > osft_pkg::MAX_PRESSURE);
      do_step   = !open_loop && (pulse_sat > cfg.step_interval);

      below = item.sensor_reading < cfg.sensor_target;
      lean  = cfg.wideband_mode ? !below : below;

      hi_lim   = {1'b0, osft_pkg::NEUTRAL_TRIM} + {2'd0, cfg.trim_limit};
      lean_sum = {1'b0, trim_cur} + {2'd0, cfg.step_size};
      lean_val = (lean_sum > hi_lim) ? hi_lim[7:0] : lean_sum[7:0];

      lo_lim     = $signed({2'b00, osft_pkg::NEUTRAL_TRIM}) - $signed({3'b000, cfg.trim_limit});
      rich_diff  = $signed({2'b00, trim_cur}) - $signed({3'b000, cfg.step_size});
      rich_clamp = (rich_diff < lo_lim) ? lo_lim : rich_diff;
      rich_val   = (rich_clamp < 10'sd0) ? 8'd0 : rich_clamp[7:0];

      trim_next  = trim_cur;
      pulse_next = pulse_sat;
      if (open_loop) begin
         trim_next  = osft_pkg::NEUTRAL_TRIM;
         pulse_next = 8'd0;
      end else if (do_step) begin
         pulse_next = 8'd0;
         if (item.sensor_reading != cfg.sensor_target) begin
            trim_next = lean ? lean_val : rich_val;
         end
      end

      result.correction = trim_next;
      result.loop_open  = open_loop;
      result.stepped    = do_step;
   end

endmodule
